### design/stkt_pkg.sv
// Package for the sorted triple-key table: command and status codes and the key compare.
// Depends on nothing; used by stkt_cmp and the top level.
`timescale 1ns / 1ps
package stkt_pkg;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_SORT   = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_SEARCH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   localparam int unsigned POS_WIDTH = 10;

   typedef struct packed {
      logic less;
      logic equal;
   } cmp_type;

endpackage

### design/stkt_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module stkt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### design/stkt_cmp.sv
// Lexicographic three-field compare of a stored entry against a key.
// Depends on stkt_pkg.
`timescale 1ns / 1ps
module stkt_cmp #(
   parameter int unsigned FW = 64
) (
   input  logic [3*FW-1:0]       entry,
   input  logic [3*FW-1:0]       key,
   output stkt_pkg::cmp_type     result
);
   import stkt_pkg::*;

   // The packed word keeps the first field on top, so one wide compare is lexicographic.
   always_comb begin
      result.less  = entry < key;
      result.equal = entry == key;
   end
endmodule

### design/sorted_triple_key_table_top.sv
// Top level of the sorted triple-key table: command sequencer around one entry memory.
// Depends on stkt_pkg, stkt_ram and stkt_cmp.
// Append writes at the end; search halves the range, then compares at the lower bound; check
//   compares each adjacent pair; sort is an insertion sort that shifts larger entries up.
// The next transaction is accepted in the result cycle. Synchronous active-high reset
//   empties the table; no clearing pass. Results cannot stall.
`timescale 1ns / 1ps
module sorted_triple_key_table_top #(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned FIELD_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [63:0] req_key_first,
   input  logic [63:0] req_key_second,
   input  logic [63:0] req_key_third,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_position
);
   import stkt_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = AW + 1;
   localparam int unsigned EW = 3 * FIELD_WIDTH;

   // One-hot sequencer states. The sort walks i upward; for each i the held key
   // is compared with entry j-1, and larger entries are shifted up one place.
   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_SRD    = 11'b00000000010,  // search: read mid, or lower bound once the range is empty
      S_SCMP   = 11'b00000000100,  // search: compare mid
      S_SFIN   = 11'b00000001000,  // search: compare at lower bound
      S_CRD    = 11'b00000010000,  // check: read entry i-1
      S_CCMP   = 11'b00000100000,  // check: read entry i, compare
      S_OLOAD  = 11'b00001000000,  // sort: read entry i as held key
      S_OCMP   = 11'b00010000000,  // sort: compare entry j-1
      S_OMOVE  = 11'b00100000000,  // sort: write shifted entry to j
      S_ORD    = 11'b01000000000,  // sort: read entry j-1, or place key at zero
      S_DONE   = 11'b10000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in, j_ff, j_in;
   logic [EW-1:0]    key_ff, key_in, prev_ff, prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic [9:0]       pos_ff, pos_in;
   logic             read_pend_ff, read_pend_in;

   logic             ram_we;
   logic [AW-1:0]    ram_addr;
   logic [EW-1:0]    ram_wdata, ram_rdata;
   logic [CW-1:0]    mid;
   cmp_type          cmp_key, cmp_prev;
   logic [EW-1:0]    req_key;

   assign req_key = {req_key_first[FIELD_WIDTH-1:0], req_key_second[FIELD_WIDTH-1:0],
                     req_key_third[FIELD_WIDTH-1:0]};
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);

   stkt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   // Read data against the search or held sort key.
   stkt_cmp #(.FW(FIELD_WIDTH)) u_cmp_key (
      .entry(ram_rdata), .key(key_ff), .result(cmp_key)
   );
   // Check: earlier entry (held) against the freshly read later one.
   stkt_cmp #(.FW(FIELD_WIDTH)) u_cmp_prev (
      .entry(ram_rdata), .key(prev_ff), .result(cmp_prev)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      key_in       = key_ff;
      prev_in      = prev_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      pos_in       = pos_ff;
      read_pend_in = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = idx_ff[AW-1:0];
      ram_wdata    = key_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = ST_OK;
               pos_in    = '0;
               case (cmd_type'(req_cmd))
                  CMD_APPEND: begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_addr  = count_ff[AW-1:0];
                        ram_wdata = req_key;
                        count_in  = count_ff + 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  CMD_SORT: begin
                     idx_in   = CW'(1);
                     state_in = (count_ff > CW'(1)) ? S_OLOAD : S_DONE;
                  end
                  CMD_CHECK: begin
                     idx_in   = CW'(1);
                     state_in = (count_ff > CW'(1)) ? S_CRD : S_DONE;
                  end
                  CMD_SEARCH: begin
                     key_in   = req_key;
                     lo_in    = '0;
                     hi_in    = count_ff;
                     state_in = S_SRD;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SRD: begin
            if (lo_ff < hi_ff) begin
               ram_addr = mid[AW-1:0];
               state_in = S_SCMP;
            end else if (lo_ff < count_ff) begin
               ram_addr = lo_ff[AW-1:0];
               state_in = S_SFIN;
            end else begin
               status_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end
         end
         S_SCMP: begin
            if (cmp_key.less) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = S_SRD;
         end
         S_SFIN: begin
            if (cmp_key.equal) begin
               pos_in = POS_WIDTH'(lo_ff);
            end else begin
               status_in = ST_NOTFOUND;
            end
            state_in = S_DONE;
         end
         S_CRD: begin
            ram_addr     = idx_ff[AW-1:0] - 1'b1;
            read_pend_in = 1'b1;
            state_in     = S_CCMP;
         end
         S_CCMP: begin
            if (read_pend_ff) begin
               prev_in      = ram_rdata;
               ram_addr     = idx_ff[AW-1:0];
               state_in     = S_CCMP;
            end else begin
               // Out of order when the later entry is below the earlier one.
               if (cmp_prev.less) begin
                  status_in = ST_NOTFOUND;
                  state_in  = S_DONE;
               end else if (idx_ff + 1'b1 < count_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_CRD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_OLOAD: begin
            // Issue read of entry i; S_OCMP takes the read data as the held key.
            ram_addr     = idx_ff[AW-1:0];
            read_pend_in = 1'b1;
            j_in         = idx_ff;
            state_in     = S_OCMP;
         end
         S_OCMP: begin
            if (read_pend_ff) begin
               key_in   = ram_rdata;
               ram_addr = j_ff[AW-1:0] - 1'b1;
            end else if (!cmp_key.less && !cmp_key.equal) begin
               // Entry j-1 is larger: shift it up, then look one place lower.
               prev_in  = ram_rdata;
               state_in = S_OMOVE;
            end else begin
               ram_we   = 1'b1;
               ram_addr = j_ff[AW-1:0];
               ram_wdata = key_ff;
               if (idx_ff + 1'b1 < count_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_OLOAD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_OMOVE: begin
            ram_we    = 1'b1;
            ram_addr  = j_ff[AW-1:0];
            ram_wdata = prev_ff;
            j_in      = j_ff - 1'b1;
            state_in  = S_ORD;
         end
         S_ORD: begin
            // The single port is free again: place the key at the bottom, or
            // fetch the next lower entry for another compare.
            if (j_ff == '0) begin
               ram_we    = 1'b1;
               ram_addr  = '0;
               ram_wdata = key_ff;
               if (idx_ff + 1'b1 < count_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_OLOAD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               ram_addr = j_ff[AW-1:0] - 1'b1;
               state_in = S_OCMP;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         read_pend_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         read_pend_ff <= read_pend_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      key_ff    <= key_in;
      prev_ff   <= prev_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_position = pos_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result while busy");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(TABLE_DEPTH))
      else $error("count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction not started");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOTFOUND
                     || rsp_status == ST_FULL))
      else $error("bad status");
endmodule
